[hdl/fpdu_pkg.sv]
// Shared types and constants of the FSK period demodulator / UART receiver.
// Used by every module under hdl/; depends on nothing else.
package fpdu_pkg;

  localparam int CAP_IN_W      = 16;  // width of the capture_time port
  localparam int CAPTURE_W_DEF = 16;  // default timer width
  localparam int THR_W         = 16;  // threshold register width
  localparam int CNT_W         = 4;   // cycle counter and per-bit register width
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int BITQ_DEPTH    = 4;   // bit queue between front and back
  localparam int BIT_IDX_W     = 4;

  localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(50);
  localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(475);
  localparam logic [CNT_W-1:0] MARK_PPB_RST  = CNT_W'(2);
  localparam logic [CNT_W-1:0] SPACE_PPB_RST = CNT_W'(4);

  // frame bit positions after the start bit
  localparam logic [BIT_IDX_W-1:0] LAST_DATA_IDX = BIT_IDX_W'(8);
  localparam logic [BIT_IDX_W-1:0] STOP1_IDX     = BIT_IDX_W'(9);
  localparam logic [BIT_IDX_W-1:0] STOP2_IDX     = BIT_IDX_W'(10);
  localparam logic [1:0]           SYNC_ONES_REQ = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR   = 2'd0,
    REG_HIGH_THR  = 2'd1,
    REG_MARK_PPB  = 2'd2,
    REG_SPACE_PPB = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] high_thr;
    logic [CNT_W-1:0] mark_ppb;
    logic [CNT_W-1:0] space_ppb;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic bit_val;
  } bit_evt_t;

  typedef enum logic [1:0] {
    MODE_SYNC    = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_READING = 2'd2
  } frame_mode_t;

endpackage

[hdl/fpdu_front.sv]
// Front end: takes capture timestamps, forms periods, classifies them and
// counts mark/space cycles into bit events. Depends on fpdu_pkg.
module fpdu_front #(
  parameter int CAPTURE_WIDTH = fpdu_pkg::CAPTURE_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [fpdu_pkg::CAP_IN_W-1:0] capture_time,
  input  fpdu_pkg::cfg_t                cfg,
  output fpdu_pkg::bit_evt_t            evt
);

  localparam int EXT_W = (CAPTURE_WIDTH > fpdu_pkg::CAP_IN_W) ? CAPTURE_WIDTH
                                                              : fpdu_pkg::CAP_IN_W;
  localparam int CMP_W = (CAPTURE_WIDTH > fpdu_pkg::THR_W) ? CAPTURE_WIDTH
                                                           : fpdu_pkg::THR_W;

  logic [CAPTURE_WIDTH-1:0]  last_r, last_nxt;
  logic                      have_last_r, have_last_nxt;
  logic [fpdu_pkg::CNT_W-1:0] mark_r, mark_nxt, space_r, space_nxt;
  logic [fpdu_pkg::CNT_W-1:0] mark_inc, space_inc;

  logic [EXT_W-1:0]          cap_ext;
  logic [CAPTURE_WIDTH-1:0]  now;
  logic [CAPTURE_WIDTH-1:0]  period;
  logic [CMP_W-1:0]          period_c, low_c, high_c;
  logic                      is_mark, is_space;

  assign cap_ext  = EXT_W'(capture_time);
  assign now      = cap_ext[CAPTURE_WIDTH-1:0];
  assign period   = now - last_r;
  assign period_c = CMP_W'(period);
  assign low_c    = CMP_W'(cfg.low_thr);
  assign high_c   = CMP_W'(cfg.high_thr);
  assign is_mark  = period_c > high_c;
  assign is_space = (period_c > low_c) && (period_c < high_c);
  assign mark_inc  = mark_r + 1'b1;
  assign space_inc = space_r + 1'b1;

  always_comb begin
    last_nxt      = last_r;
    have_last_nxt = have_last_r;
    mark_nxt      = mark_r;
    space_nxt     = space_r;
    evt           = '0;
    if (take) begin
      last_nxt      = now;
      have_last_nxt = 1'b1;
      if (have_last_r) begin
        if (is_mark) begin
          // count mark cycles; a full count yields a one
          if (mark_inc == cfg.mark_ppb) begin
            mark_nxt    = '0;
            evt.push    = 1'b1;
            evt.bit_val = 1'b1;
          end else begin
            mark_nxt = mark_inc;
          end
        end else if (is_space) begin
          if (space_inc == cfg.space_ppb) begin
            space_nxt   = '0;
            evt.push    = 1'b1;
            evt.bit_val = 1'b0;
          end else begin
            space_nxt = space_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      have_last_r <= 1'b0;
      mark_r      <= '0;
      space_r     <= '0;
    end else begin
      last_r      <= last_nxt;
      have_last_r <= have_last_nxt;
      mark_r      <= mark_nxt;
      space_r     <= space_nxt;
    end
  end

endmodule

[hdl/fpdu_bitq.sv]
// Short queue of demodulated bits between front and back end.
// Depends on fpdu_pkg for its default depth.
module fpdu_bitq #(
  parameter int WIDTH = 1,
  parameter int DEPTH = fpdu_pkg::BITQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             head_valid,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = count_r == DEPTH_C;
  assign head_valid = count_r != '0;
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("bit queue count above depth");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (count_r == '0))
    else $error("bit queue not empty after reset");

endmodule

[hdl/fpdu_back.sv]
// Back end: UART-style frame decoder driven by the queued bits, with the
// output byte register. Depends on fpdu_pkg.
module fpdu_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  logic                        head_bit,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fpdu_pkg::BYTE_W-1:0] out_received_byte
);

  fpdu_pkg::frame_mode_t              state_r, state_nxt;
  logic [1:0]                         sync_ones_r, sync_ones_nxt;
  logic [fpdu_pkg::BIT_IDX_W-1:0]     bit_idx_r, bit_idx_nxt, idx_inc;
  logic [fpdu_pkg::BYTE_W-1:0]        shift_r, shift_nxt;
  logic [fpdu_pkg::BYTE_W-1:0]        byte_r, byte_nxt;
  logic                               valid_r, valid_nxt;
  logic                               slot_free, will_emit;
  logic [1:0]                         ones_inc;

  assign idx_inc   = bit_idx_r + 1'b1;
  assign ones_inc  = sync_ones_r + 1'b1;
  assign slot_free = !valid_r || !out_stall;
  assign will_emit = (state_r == fpdu_pkg::MODE_READING) && (idx_inc == fpdu_pkg::STOP2_IDX);
  assign pop       = head_valid && (slot_free || !will_emit);

  always_comb begin
    state_nxt     = state_r;
    sync_ones_nxt = sync_ones_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    byte_nxt      = byte_r;
    valid_nxt     = valid_r && out_stall;
    if (pop) begin
      unique case (state_r)
        fpdu_pkg::MODE_IDLE: begin
          if (!head_bit) begin
            state_nxt = fpdu_pkg::MODE_READING;
          end
        end
        fpdu_pkg::MODE_READING: begin
          bit_idx_nxt = idx_inc;
          if (idx_inc <= fpdu_pkg::LAST_DATA_IDX) begin
            shift_nxt = shift_r | ({{(fpdu_pkg::BYTE_W-1){1'b0}}, head_bit}
                                   << (idx_inc[2:0] - 3'd1));
          end else if (idx_inc == fpdu_pkg::STOP2_IDX) begin
            byte_nxt    = shift_r;
            valid_nxt   = 1'b1;
            shift_nxt   = '0;
            bit_idx_nxt = '0;
            state_nxt   = fpdu_pkg::MODE_IDLE;
          end
        end
        default: begin
          // sync: wait for two consecutive ones
          if (head_bit) begin
            sync_ones_nxt = ones_inc;
            state_nxt     = (ones_inc == fpdu_pkg::SYNC_ONES_REQ) ? fpdu_pkg::MODE_IDLE
                                                                  : fpdu_pkg::MODE_SYNC;
          end else begin
            sync_ones_nxt = '0;
            state_nxt     = fpdu_pkg::MODE_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpdu_pkg::MODE_SYNC;
      sync_ones_r <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sync_ones_r <= sync_ones_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign out_valid         = valid_r;
  assign out_received_byte = byte_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r <= fpdu_pkg::STOP2_IDX)
    else $error("frame bit index out of range");

  a_rose_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(pop && will_emit))
    else $error("byte appeared without a finished frame");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpdu_pkg::MODE_IDLE) |-> (bit_idx_r == '0 && shift_r == '0))
    else $error("idle decoder holds stale frame data");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !(pop && will_emit))
    else $error("pending byte overwritten");

endmodule

[hdl/fsk_period_demod_uart_receiver.sv]
// Top level of the FSK period demodulator and UART-style frame receiver.
// Holds the configuration registers; depends on fpdu_pkg, fpdu_front,
// fpdu_bitq and fpdu_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_capture_time): one transaction per
//   timer capture taken at a signal edge. The first capture after reset only
//   seeds the period timer. The front end computes the period, classifies it
//   as mark, space or glitch and counts cycles into bits.
//   Result channel (out_valid / out_stall / out_received_byte): one
//   transaction per decoded frame, first data bit in bit 0.
//   Configuration port (cfg_we / cfg_index / cfg_wdata): write thresholds and
//   cycles-per-bit counts while the block is idle; no read-back.
// Throughput: one capture per clock while in_stall is low. The front end
//   finishes each capture in the cycle it is accepted; a demodulated bit
//   waits in a four-entry queue and the frame decoder takes one bit per cycle
//   unless a finished frame waits behind out_stall. The bit that completes a
//   frame is queued, then the decoder registers the byte onto out_valid.
// Reset: rst_n clears counters, the decoder (back to sync, waiting for two
//   ones) and the queue, and loads the default configuration.
// Stall: while out_stall holds a pending byte, the decoder keeps taking bits
//   that do not finish a frame; once the queue fills, in_stall rises.
module fsk_period_demod_uart_receiver #(
  parameter int CAPTURE_WIDTH = fpdu_pkg::CAPTURE_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fpdu_pkg::CAP_IN_W-1:0]   in_capture_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fpdu_pkg::BYTE_W-1:0]     out_received_byte,
  input  logic                            cfg_we,
  input  logic [fpdu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpdu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fpdu_pkg::cfg_t     cfg_r, cfg_nxt;
  fpdu_pkg::bit_evt_t evt;
  logic               take;
  logic               q_full, q_head_valid, q_head_bit, q_pop;

  // register file: decode the index and keep the low bits of the data
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (fpdu_pkg::cfg_reg_t'(cfg_index))
        fpdu_pkg::REG_LOW_THR:   cfg_nxt.low_thr   = cfg_wdata[fpdu_pkg::THR_W-1:0];
        fpdu_pkg::REG_HIGH_THR:  cfg_nxt.high_thr  = cfg_wdata[fpdu_pkg::THR_W-1:0];
        fpdu_pkg::REG_MARK_PPB:  cfg_nxt.mark_ppb  = cfg_wdata[fpdu_pkg::CNT_W-1:0];
        fpdu_pkg::REG_SPACE_PPB: cfg_nxt.space_ppb = cfg_wdata[fpdu_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr   <= fpdu_pkg::LOW_THR_RST;
      cfg_r.high_thr  <= fpdu_pkg::HIGH_THR_RST;
      cfg_r.mark_ppb  <= fpdu_pkg::MARK_PPB_RST;
      cfg_r.space_ppb <= fpdu_pkg::SPACE_PPB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // hold off captures only when the bit queue cannot take another bit
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  fpdu_front #(
    .CAPTURE_WIDTH(CAPTURE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .capture_time(in_capture_time),
    .cfg         (cfg_r),
    .evt         (evt)
  );

  fpdu_bitq #(
    .WIDTH(1),
    .DEPTH(fpdu_pkg::BITQ_DEPTH)
  ) u_bitq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt.push),
    .push_data (evt.bit_val),
    .pop       (q_pop),
    .head_data (q_head_bit),
    .head_valid(q_head_valid),
    .full      (q_full)
  );

  fpdu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_bit         (q_head_bit),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_received_byte(out_received_byte)
  );

endmodule
